// ===== hdl/tcr_pkg.sv =====
// shared constants and types of the ternary clause resolver
`default_nettype none

package tcr_pkg;

  // default literal width (variable index times two plus sign bit)
  localparam int unsigned LitWidthDefault = 30;

  // literal slots of the collected resolvent: three from each clause
  localparam int unsigned NumSlots = 6;

  // resolution outcome codes
  typedef enum logic [1:0] {
    OUT_TAUT    = 2'd0,
    OUT_DISCARD = 2'd1,
    OUT_BINARY  = 2'd2,
    OUT_TERNARY = 2'd3
  } outcome_e;

endpackage : tcr_pkg

`default_nettype wire

// ===== hdl/tcr_if.sv =====
// request and result channel interfaces of the ternary clause resolver
`default_nettype none

interface tcr_req_if #(
  parameter int unsigned LitWidth = tcr_pkg::LitWidthDefault
);
  logic                valid;
  logic                ready;
  logic [LitWidth-1:0] pivot;
  logic [LitWidth-1:0] c_lit_a;
  logic [LitWidth-1:0] c_lit_b;
  logic [LitWidth-1:0] c_lit_c;
  logic [LitWidth-1:0] d_lit_a;
  logic [LitWidth-1:0] d_lit_b;
  logic [LitWidth-1:0] d_lit_c;
  logic                c_learned;
  logic                d_learned;

  modport source (
    output valid, pivot, c_lit_a, c_lit_b, c_lit_c, d_lit_a, d_lit_b, d_lit_c,
           c_learned, d_learned,
    input  ready
  );
  modport sink (
    input  valid, pivot, c_lit_a, c_lit_b, c_lit_c, d_lit_a, d_lit_b, d_lit_c,
           c_learned, d_learned,
    output ready
  );
endinterface : tcr_req_if

interface tcr_res_if #(
  parameter int unsigned LitWidth = tcr_pkg::LitWidthDefault
);
  logic                valid;
  logic                ready;
  logic [1:0]          outcome;
  logic [LitWidth-1:0] res_lit_a;
  logic [LitWidth-1:0] res_lit_b;
  logic [LitWidth-1:0] res_lit_c;
  logic                res_learned;
  logic                antecedents_subsumed;

  modport source (
    output valid, outcome, res_lit_a, res_lit_b, res_lit_c, res_learned,
           antecedents_subsumed,
    input  ready
  );
  modport sink (
    input  valid, outcome, res_lit_a, res_lit_b, res_lit_c, res_learned,
           antecedents_subsumed,
    output ready
  );
endinterface : tcr_res_if

`default_nettype wire

// ===== hdl/ternary_clause_resolver_unit.sv =====
// ternary clause resolver: three-stage pipeline resolving two ternary clauses
// usage:
//   req_i carries one request: a pivot literal, clause c holding the pivot,
//   clause d holding its complement, and the learned flags of both clauses
//   res_o carries one result per request: outcome code, up to three resolvent
//   literals in order, the learned flag of the resolvent and a flag that marks
//   both antecedents as subsumed (binary resolvent only)
//   a request is taken at a rising edge with valid and ready both high
// stages: a request moves through the stage 1, stage 2 and output registers
//   stage 1 compares all literals in parallel, stage 2 walks the d literals
//   through the duplicate and tautology decision, stage 3 packs the literals
//   into the output register
// throughput: one request per cycle unless stalled; each stage holds one
//   request, the output register the finished result while the next move up
// stall: when the receiver holds ready low the output register keeps its
//   result, and the stages behind it fill up before req_i.ready drops
// reset: all stage valid bits clear, so no result is shown until a request
//   has gone through; payload registers are not reset
`default_nettype none

module ternary_clause_resolver_unit #(
  parameter int unsigned LitWidth = tcr_pkg::LitWidthDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  tcr_req_if.sink      req_i,
  tcr_res_if.source    res_o
);

  localparam logic [LitWidth-1:0] LitOne = LitWidth'(1);
  localparam int unsigned NumSlots = tcr_pkg::NumSlots;

  // ---------------------------------------------------------------------------
  // handshake: a stage may load when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, res_valid_q;
  logic out_adv, s2_adv, s1_adv;

  assign out_adv     = !res_valid_q || res_o.ready;
  assign s2_adv      = !s2_valid_q || out_adv;
  assign s1_adv      = !s1_valid_q || s2_adv;
  assign req_i.ready = s1_adv;

  // ---------------------------------------------------------------------------
  // stage 1: literal compares
  // ---------------------------------------------------------------------------
  logic [LitWidth-1:0] req_c [3];
  logic [LitWidth-1:0] req_d [3];
  logic [LitWidth-1:0] npiv;

  // keep bits: c literal is not the pivot, d literal is not its complement
  logic [2:0]          s1_ckeep_d, s1_ckeep_q;
  logic [2:0]          s1_dkeep_d, s1_dkeep_q;
  // d literal i against c literal k: equal / complementary
  logic [2:0]          s1_eqc_d [3];
  logic [2:0]          s1_eqc_q [3];
  logic [2:0]          s1_cmc_d [3];
  logic [2:0]          s1_cmc_q [3];
  // d against earlier d: bit 0 d1-d0, bit 1 d2-d0, bit 2 d2-d1
  logic [2:0]          s1_eqd_d, s1_eqd_q;
  logic [2:0]          s1_cmd_d, s1_cmd_q;
  logic [LitWidth-1:0] s1_lits_q [NumSlots];
  logic                s1_cl_q, s1_dl_q;

  assign req_c[0] = req_i.c_lit_a;
  assign req_c[1] = req_i.c_lit_b;
  assign req_c[2] = req_i.c_lit_c;
  assign req_d[0] = req_i.d_lit_a;
  assign req_d[1] = req_i.d_lit_b;
  assign req_d[2] = req_i.d_lit_c;
  assign npiv     = req_i.pivot ^ LitOne;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_ckeep_d[i] = (req_c[i] != req_i.pivot);
      s1_dkeep_d[i] = (req_d[i] != npiv);
      for (int k = 0; k < 3; k++) begin
        s1_eqc_d[i][k] = (req_d[i] == req_c[k]);
        s1_cmc_d[i][k] = ((req_d[i] ^ LitOne) == req_c[k]);
      end
    end
    s1_eqd_d[0] = (req_d[1] == req_d[0]);
    s1_eqd_d[1] = (req_d[2] == req_d[0]);
    s1_eqd_d[2] = (req_d[2] == req_d[1]);
    s1_cmd_d[0] = ((req_d[1] ^ LitOne) == req_d[0]);
    s1_cmd_d[1] = ((req_d[2] ^ LitOne) == req_d[0]);
    s1_cmd_d[2] = ((req_d[2] ^ LitOne) == req_d[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && req_i.valid) begin
      s1_ckeep_q <= s1_ckeep_d;
      s1_dkeep_q <= s1_dkeep_d;
      s1_eqc_q   <= s1_eqc_d;
      s1_cmc_q   <= s1_cmc_d;
      s1_eqd_q   <= s1_eqd_d;
      s1_cmd_q   <= s1_cmd_d;
      for (int i = 0; i < 3; i++) begin
        s1_lits_q[i]   <= req_c[i];
        s1_lits_q[i+3] <= req_d[i];
      end
      s1_cl_q <= req_i.c_learned;
      s1_dl_q <= req_i.d_learned;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: walk d literals in order; the first matching collected literal
  // decides: equal means duplicate, complementary means tautology (scan stops)
  // ---------------------------------------------------------------------------
  logic [2:0]          s2_app;
  logic                s2_taut_d;
  logic [2:0]          s2_size_d;
  logic                hit, hit_cm;

  logic                s2_taut_q;
  logic [2:0]          s2_size_q;
  logic [NumSlots-1:0] s2_mask_q;
  logic [LitWidth-1:0] s2_lits_q [NumSlots];
  logic                s2_cl_q, s2_dl_q;

  always_comb begin
    s2_app    = 3'b000;
    s2_taut_d = 1'b0;
    hit       = 1'b0;
    hit_cm    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      hit    = 1'b0;
      hit_cm = 1'b0;
      for (int k = 0; k < 3; k++) begin
        if (!hit && s1_ckeep_q[k] && (s1_eqc_q[i][k] || s1_cmc_q[i][k])) begin
          hit    = 1'b1;
          hit_cm = s1_cmc_q[i][k];
        end
      end
      if (i == 1) begin
        if (!hit && s2_app[0] && (s1_eqd_q[0] || s1_cmd_q[0])) begin
          hit    = 1'b1;
          hit_cm = s1_cmd_q[0];
        end
      end else if (i == 2) begin
        if (!hit && s2_app[0] && (s1_eqd_q[1] || s1_cmd_q[1])) begin
          hit    = 1'b1;
          hit_cm = s1_cmd_q[1];
        end
        if (!hit && s2_app[1] && (s1_eqd_q[2] || s1_cmd_q[2])) begin
          hit    = 1'b1;
          hit_cm = s1_cmd_q[2];
        end
      end
      if (!s2_taut_d && s1_dkeep_q[i]) begin
        if (hit && hit_cm) begin
          s2_taut_d = 1'b1;
        end else if (!hit) begin
          s2_app[i] = 1'b1;
        end
      end
    end
    s2_size_d = 3'(s1_ckeep_q[0]) + 3'(s1_ckeep_q[1]) + 3'(s1_ckeep_q[2])
              + 3'(s2_app[0]) + 3'(s2_app[1]) + 3'(s2_app[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      s2_taut_q <= s2_taut_d;
      s2_size_q <= s2_size_d;
      s2_mask_q <= {s2_app, s1_ckeep_q};
      s2_lits_q <= s1_lits_q;
      s2_cl_q   <= s1_cl_q;
      s2_dl_q   <= s1_dl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: pack kept literals in order and decode the outcome
  // ---------------------------------------------------------------------------
  logic [LitWidth-1:0] pick [3];
  logic [2:0]          cnt;
  tcr_pkg::outcome_e   outcome_d;
  logic [LitWidth-1:0] lit_a_d, lit_b_d, lit_c_d;
  logic                learned_d, subsumed_d;

  tcr_pkg::outcome_e   outcome_q;
  logic [LitWidth-1:0] lit_a_q, lit_b_q, lit_c_q;
  logic                learned_q, subsumed_q;

  always_comb begin
    cnt = 3'd0;
    for (int p = 0; p < 3; p++) begin
      pick[p] = '0;
    end
    for (int n = 0; n < NumSlots; n++) begin
      if (s2_mask_q[n]) begin
        if (cnt == 3'd0) begin
          pick[0] = s2_lits_q[n];
        end else if (cnt == 3'd1) begin
          pick[1] = s2_lits_q[n];
        end else if (cnt == 3'd2) begin
          pick[2] = s2_lits_q[n];
        end
        cnt = cnt + 3'd1;
      end
    end

    outcome_d  = tcr_pkg::OUT_DISCARD;
    lit_a_d    = '0;
    lit_b_d    = '0;
    lit_c_d    = '0;
    learned_d  = 1'b0;
    subsumed_d = 1'b0;
    priority if (s2_taut_q) begin
      outcome_d = tcr_pkg::OUT_TAUT;
    end else if (s2_size_q == 3'd3) begin
      outcome_d = tcr_pkg::OUT_TERNARY;
      lit_a_d   = pick[0];
      lit_b_d   = pick[1];
      lit_c_d   = pick[2];
      learned_d = 1'b1;
    end else if (s2_size_q == 3'd2) begin
      // binary resolvent subsumes both antecedents
      outcome_d  = tcr_pkg::OUT_BINARY;
      lit_a_d    = pick[0];
      lit_b_d    = pick[1];
      learned_d  = s2_cl_q && s2_dl_q;
      subsumed_d = 1'b1;
    end else begin
      outcome_d = tcr_pkg::OUT_DISCARD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_adv) begin
      res_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s2_valid_q) begin
      outcome_q  <= outcome_d;
      lit_a_q    <= lit_a_d;
      lit_b_q    <= lit_b_d;
      lit_c_q    <= lit_c_d;
      learned_q  <= learned_d;
      subsumed_q <= subsumed_d;
    end
  end

  assign res_o.valid                = res_valid_q;
  assign res_o.outcome              = outcome_q;
  assign res_o.res_lit_a            = lit_a_q;
  assign res_o.res_lit_b            = lit_b_q;
  assign res_o.res_lit_c            = lit_c_q;
  assign res_o.res_learned          = learned_q;
  assign res_o.antecedents_subsumed = subsumed_q;

endmodule : ternary_clause_resolver_unit

`default_nettype wire

// ===== hdl/tcr_checker.sv =====
// port-level checker of the ternary clause resolver and its bind
`default_nettype none

module tcr_checker #(
  parameter int unsigned LitWidth = tcr_pkg::LitWidthDefault
) (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                valid_i,
  input wire                ready_i,
  input wire [1:0]          outcome_i,
  input wire [LitWidth-1:0] lit_a_i,
  input wire [LitWidth-1:0] lit_b_i,
  input wire [LitWidth-1:0] lit_c_i,
  input wire                learned_i,
  input wire                subsumed_i
);

  // result stays valid, with outcome and first literal held, while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(outcome_i) && $stable(lit_a_i))
    else $error("stalled result changed");

  // unusable resolvents carry no literals or flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (outcome_i == tcr_pkg::OUT_TAUT || outcome_i == tcr_pkg::OUT_DISCARD)
    |-> lit_a_i == '0 && lit_b_i == '0 && lit_c_i == '0 && !learned_i && !subsumed_i)
    else $error("unusable resolvent with payload");

  // binary resolvent subsumes antecedents and has no third literal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && outcome_i == tcr_pkg::OUT_BINARY |-> subsumed_i && lit_c_i == '0)
    else $error("binary resolvent flags wrong");

  // ternary resolvent is always learned and never subsumes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && outcome_i == tcr_pkg::OUT_TERNARY |-> learned_i && !subsumed_i)
    else $error("ternary resolvent flags wrong");

endmodule : tcr_checker

bind ternary_clause_resolver_unit tcr_checker #(
  .LitWidth (LitWidth)
) u_tcr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_i    (res_o.valid),
  .ready_i    (res_o.ready),
  .outcome_i  (res_o.outcome),
  .lit_a_i    (res_o.res_lit_a),
  .lit_b_i    (res_o.res_lit_b),
  .lit_c_i    (res_o.res_lit_c),
  .learned_i  (res_o.res_learned),
  .subsumed_i (res_o.antecedents_subsumed)
);

`default_nettype wire

// ===== sim/tb_ternary_clause_resolver_unit.sv =====
// testbench of the ternary clause resolver: directed and random requests against a scoreboard
`default_nettype none

module tb_ternary_clause_resolver_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LitWidth = tcr_pkg::LitWidthDefault;
  localparam int unsigned NumSlots = tcr_pkg::NumSlots;
  // no-progress limit in cycles: far above the longest receiver hold-off plus sender gap
  localparam int unsigned IdleLimit = 2000;
  // cycles to linger after the last result
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandomRequests = 500;
  // long receiver hold-off that fills the pipeline and stalls the request side
  localparam int unsigned HoldOffStart = 150;
  localparam int unsigned HoldOffCycles = 80;

  typedef logic [LitWidth-1:0] lit_t;
  localparam int unsigned LitMax = (32'd1 << LitWidth) - 32'd1;

  typedef struct packed {
    lit_t pivot;
    lit_t c_lit_a;
    lit_t c_lit_b;
    lit_t c_lit_c;
    lit_t d_lit_a;
    lit_t d_lit_b;
    lit_t d_lit_c;
    logic c_learned;
    logic d_learned;
  } clause_pair_t;

  typedef struct packed {
    tcr_pkg::outcome_e outcome;
    lit_t              res_lit_a;
    lit_t              res_lit_b;
    lit_t              res_lit_c;
    logic              res_learned;
    logic              antecedents_subsumed;
  } resolvent_t;

  // resolve c and d on the pivot, the way the block is meant to
  function automatic resolvent_t resolve_clauses(clause_pair_t r);
    lit_t        c_lits[3];
    lit_t        d_lits[3];
    lit_t        kept[NumSlots];
    lit_t        neg_pivot;
    int unsigned n_kept;
    int unsigned j;
    bit          taut;
    bit          dup;
    resolvent_t  res;
    c_lits = '{r.c_lit_a, r.c_lit_b, r.c_lit_c};
    d_lits = '{r.d_lit_a, r.d_lit_b, r.d_lit_c};
    neg_pivot = r.pivot ^ lit_t'(1);
    n_kept = 0;
    taut = 1'b0;
    // every literal of c except the pivot, in order, duplicates included
    for (int i = 0; i < 3; i++) begin
      if (c_lits[i] != r.pivot) begin
        kept[n_kept] = c_lits[i];
        n_kept++;
      end
    end
    // d literals: first equal literal wins over a later complement
    for (int i = 0; i < 3; i++) begin
      if (!taut && d_lits[i] != neg_pivot) begin
        dup = 1'b0;
        j = 0;
        while (j < n_kept && !dup && !taut) begin
          if (d_lits[i] == kept[j]) dup = 1'b1;
          else if ((d_lits[i] ^ lit_t'(1)) == kept[j]) taut = 1'b1;
          j++;
        end
        if (!taut && !dup && n_kept < NumSlots) begin
          kept[n_kept] = d_lits[i];
          n_kept++;
        end
      end
    end
    res = '0;
    if (taut) begin
      res.outcome = tcr_pkg::OUT_TAUT;
    end else if (n_kept < 2 || n_kept > 3) begin
      res.outcome = tcr_pkg::OUT_DISCARD;
    end else begin
      res.res_lit_a = kept[0];
      res.res_lit_b = kept[1];
      if (n_kept == 3) begin
        res.outcome     = tcr_pkg::OUT_TERNARY;
        res.res_lit_c   = kept[2];
        res.res_learned = 1'b1;
      end else begin
        res.outcome              = tcr_pkg::OUT_BINARY;
        res.res_learned          = r.c_learned & r.d_learned;
        res.antecedents_subsumed = 1'b1;
      end
    end
    return res;
  endfunction

  class resolvent_scoreboard;
    resolvent_t  pending_resolvents[$];
    int unsigned mismatches;
    int unsigned outcome_seen[4];

    function void note_request(clause_pair_t r);
      pending_resolvents.push_back(resolve_clauses(r));
    endfunction

    function void check_field(string name, lit_t want, lit_t got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(resolvent_t got);
      resolvent_t want;
      if (pending_resolvents.size() == 0) begin
        $error("result with no request outstanding: outcome %0d", got.outcome);
        mismatches++;
        return;
      end
      want = pending_resolvents.pop_front();
      outcome_seen[want.outcome]++;
      check_field("outcome", lit_t'(want.outcome), lit_t'(got.outcome));
      check_field("res_lit_a", want.res_lit_a, got.res_lit_a);
      check_field("res_lit_b", want.res_lit_b, got.res_lit_b);
      check_field("res_lit_c", want.res_lit_c, got.res_lit_c);
      check_field("res_learned", lit_t'(want.res_learned), lit_t'(got.res_learned));
      check_field("antecedents_subsumed", lit_t'(want.antecedents_subsumed),
                  lit_t'(got.antecedents_subsumed));
    endfunction

    function int unsigned outstanding();
      return pending_resolvents.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tcr_req_if #(.LitWidth(LitWidth)) req_if ();
  tcr_res_if #(.LitWidth(LitWidth)) res_if ();

  ternary_clause_resolver_unit #(
    .LitWidth(LitWidth)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .res_o (res_if)
  );

  resolvent_scoreboard board = new();

  bit          saw_accept;     // any handshake seen this cycle, for the watchdog
  int unsigned sent_count;
  int unsigned input_stalls;   // cycles a request waited on ready
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // request side helpers
  // ---------------------------------------------------------------------------

  function automatic clause_pair_t make_request(int unsigned piv, int unsigned ca,
                                                int unsigned cb, int unsigned cc,
                                                int unsigned da, int unsigned db,
                                                int unsigned dc, logic cl, logic dl);
    clause_pair_t r;
    r.pivot     = lit_t'(piv);
    r.c_lit_a   = lit_t'(ca);
    r.c_lit_b   = lit_t'(cb);
    r.c_lit_c   = lit_t'(cc);
    r.d_lit_a   = lit_t'(da);
    r.d_lit_b   = lit_t'(db);
    r.d_lit_c   = lit_t'(dc);
    r.c_learned = cl;
    r.d_learned = dl;
    return r;
  endfunction

  // literal over a small window of variables, so duplicates and complements show up often
  function automatic lit_t pool_lit(int unsigned base_var, int unsigned span);
    int unsigned v;
    v = base_var + $urandom_range(0, span - 1);
    return (lit_t'(v) << 1) | lit_t'($urandom_range(0, 1));
  endfunction

  function automatic clause_pair_t build_random_request();
    clause_pair_t r;
    lit_t        c_lits[3];
    lit_t        d_lits[3];
    lit_t        piv;
    int unsigned pick;
    int unsigned span;
    int unsigned base_var;
    int unsigned c_pos;
    int unsigned d_pos;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // noise: every bit of every literal free
      r = '{pivot: lit_t'($urandom), c_lit_a: lit_t'($urandom), c_lit_b: lit_t'($urandom),
            c_lit_c: lit_t'($urandom), d_lit_a: lit_t'($urandom),
            d_lit_b: lit_t'($urandom), d_lit_c: lit_t'($urandom),
            c_learned: 1'($urandom), d_learned: 1'($urandom)};
      return r;
    end
    span = $urandom_range(2, 8);
    case ($urandom_range(0, 9))
      0: base_var = 0;
      1: base_var = (1 << (LitWidth - 1)) - span;
      default: base_var = $urandom_range(0, (1 << (LitWidth - 1)) - span);
    endcase
    piv   = pool_lit(base_var, span);
    c_pos = $urandom_range(0, 2);
    d_pos = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      // pivot in its slot, now and then a repeated pivot or complement
      if (i == c_pos || $urandom_range(0, 9) == 0) c_lits[i] = piv;
      else c_lits[i] = pool_lit(base_var, span);
      if (i == d_pos || $urandom_range(0, 9) == 0) d_lits[i] = piv ^ lit_t'(1);
      else d_lits[i] = pool_lit(base_var, span);
    end
    // a broken pair: the pivot in its slot of c is replaced by a pool literal
    if (pick < 22) c_lits[c_pos] = pool_lit(base_var, span);
    r = '{pivot: piv, c_lit_a: c_lits[0], c_lit_b: c_lits[1], c_lit_c: c_lits[2],
          d_lit_a: d_lits[0], d_lit_b: d_lits[1], d_lit_c: d_lits[2],
          c_learned: 1'($urandom), d_learned: 1'($urandom)};
    return r;
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  // called at a rising edge; returns at the edge that takes the request
  task automatic send_request(input clause_pair_t r);
    req_if.valid     <= 1'b1;
    req_if.pivot     <= r.pivot;
    req_if.c_lit_a   <= r.c_lit_a;
    req_if.c_lit_b   <= r.c_lit_b;
    req_if.c_lit_c   <= r.c_lit_c;
    req_if.d_lit_a   <= r.d_lit_a;
    req_if.d_lit_b   <= r.d_lit_b;
    req_if.d_lit_c   <= r.d_lit_c;
    req_if.c_learned <= r.c_learned;
    req_if.d_learned <= r.d_learned;
    // sample mid-cycle, where valid and ready are settled for the next edge
    @(negedge clk);
    while (!req_if.ready) begin
      input_stalls++;
      @(negedge clk);
    end
    board.note_request(r);
    sent_count++;
    saw_accept = 1'b1;
    @(posedge clk);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles > 0) begin
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence: reset, directed cases, random pairs, drain
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned burst_left;
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.pivot     = '0;
    req_if.c_lit_a   = '0;
    req_if.c_lit_b   = '0;
    req_if.c_lit_c   = '0;
    req_if.d_lit_a   = '0;
    req_if.d_lit_b   = '0;
    req_if.d_lit_c   = '0;
    req_if.c_learned = 1'b0;
    req_if.d_learned = 1'b0;
    burst_left       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes
    send_request(make_request(0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_request(make_request(LitMax, LitMax, LitMax, LitMax, LitMax, LitMax, LitMax,
                              1'b1, 1'b1));
    // tautology through a complement of a c literal
    send_request(make_request(2, 2, 4, 6, 3, 5, 8, 1'b1, 1'b1));
    idle_sender(pick_gap());
    // binary resolvent under all learned combinations
    send_request(make_request(2, 2, 4, 6, 3, 4, 6, 1'b0, 1'b0));
    send_request(make_request(2, 2, 4, 6, 3, 4, 6, 1'b0, 1'b1));
    send_request(make_request(2, 2, 4, 6, 3, 4, 6, 1'b1, 1'b0));
    send_request(make_request(2, 2, 4, 6, 3, 4, 6, 1'b1, 1'b1));
    // ternary and four literals
    send_request(make_request(2, 2, 4, 6, 3, 8, 4, 1'b0, 1'b0));
    send_request(make_request(2, 2, 4, 6, 3, 8, 10, 1'b1, 1'b1));
    idle_sender(pick_gap());
    // pivot absent from c: five literals, then three
    send_request(make_request(2, 4, 6, 8, 3, 10, 12, 1'b0, 1'b1));
    send_request(make_request(2, 4, 6, 8, 3, 4, 6, 1'b1, 1'b0));
    // repeated pivot in c, repeated complement in d
    send_request(make_request(2, 2, 2, 4, 3, 6, 4, 1'b1, 1'b1));
    send_request(make_request(2, 2, 4, 6, 3, 3, 8, 1'b0, 1'b0));
    // too few literals
    send_request(make_request(2, 2, 2, 2, 3, 3, 4, 1'b1, 1'b1));
    send_request(make_request(2, 2, 2, 4, 3, 3, 3, 1'b1, 1'b1));
    send_request(make_request(2, 2, 2, 2, 3, 3, 3, 1'b1, 1'b1));
    idle_sender(pick_gap());
    // duplicates and complements inside c stay; equal literal beats a later complement
    send_request(make_request(2, 4, 4, 2, 3, 3, 3, 1'b1, 1'b1));
    send_request(make_request(2, 4, 5, 2, 3, 4, 3, 1'b1, 1'b1));
    send_request(make_request(2, 4, 5, 2, 3, 5, 3, 1'b0, 1'b0));
    // literals at the top and bottom of the range
    send_request(make_request(LitMax, LitMax, 0, 1, LitMax - 1, LitMax - 1, LitMax - 1,
                              1'b1, 1'b1));
    send_request(make_request(32'h2AAAAAAA, 32'h15555555, 32'h2AAAAAAA, 32'h3FFFFFFD,
                              32'h2AAAAAAB, 32'h15555555, LitMax, 1'b0, 1'b1));
    send_request(make_request(1, 0, 1, LitMax, 0, LitMax - 1, 2, 1'b1, 1'b0));

    // random pairs, with bursts of back-to-back requests now and then
    repeat (RandomRequests) begin
      send_request(build_random_request());
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 40);
        idle_sender(pick_gap());
      end
    end
    req_if.valid <= 1'b0;

    // drain: every result back, then DrainCycles more clock edges to catch strays
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("resolved %0d clause pairs: %0d tautological, %0d discarded, %0d binary,",
             sent_count, board.outcome_seen[tcr_pkg::OUT_TAUT],
             board.outcome_seen[tcr_pkg::OUT_DISCARD],
             board.outcome_seen[tcr_pkg::OUT_BINARY]);
    $display("%0d ternary; requests waited %0d cycles on a full pipeline",
             board.outcome_seen[tcr_pkg::OUT_TERNARY], input_stalls);
    if (board.mismatches == 0) begin
      $display("tb_ternary_clause_resolver_unit: PASS");
    end else begin
      $display("tb_ternary_clause_resolver_unit: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: ready pattern and checking
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned hold_left;
    int unsigned run_left;
    int unsigned pick;
    bit          long_hold_done;
    res_if.ready   = 1'b0;
    hold_left      = 0;
    run_left       = 0;
    long_hold_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (!long_hold_done && sent_count >= HoldOffStart) begin
        // one long hold-off while requests keep coming: pipeline fills, input stalls
        long_hold_done = 1'b1;
        hold_left      = HoldOffCycles - 1;
        res_if.ready  <= 1'b0;
      end else if (run_left > 0) begin
        res_if.ready <= 1'b1;
        run_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          hold_left     = $urandom_range(8, 30) - 1;
          res_if.ready <= 1'b0;
        end else if (pick < 10) begin
          run_left      = $urandom_range(10, 40) - 1;
          res_if.ready <= 1'b1;
        end else begin
          res_if.ready <= ($urandom_range(0, 3) != 0);
        end
      end
    end
  end

  // results are checked mid-cycle: valid and ready there decide the next edge
  initial begin
    resolvent_t got;
    forever begin
      @(negedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        got.outcome              = tcr_pkg::outcome_e'(res_if.outcome);
        got.res_lit_a            = res_if.res_lit_a;
        got.res_lit_b            = res_if.res_lit_b;
        got.res_lit_c            = res_if.res_lit_c;
        got.res_learned          = res_if.res_learned;
        got.antecedents_subsumed = res_if.antecedents_subsumed;
        board.check_result(got);
        saw_accept = 1'b1;
      end
    end
  end

  // watchdog: too many cycles without any request or result moving
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if (saw_accept) begin
        saw_accept  = 1'b0;
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: %0d cycles without progress, %0d results outstanding",
             idle_cycles, board.outstanding());
    $display("tb_ternary_clause_resolver_unit: FAIL");
    $finish;
  end

endmodule : tb_ternary_clause_resolver_unit

`default_nettype wire
